>>> design/rdc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rdc_pkg
// Shared constants and types for the row delta codec.
// ----------------------------------------------------------------------------
package rdc_pkg;

  localparam int SampleW   = 16;
  localparam int MaxRowLen = 4096;
  localparam int ColW      = $clog2(MaxRowLen);
  localparam int LenW      = 13;
  localparam int CfgIdxW   = 1;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic [ColW-1:0]           col_t;
  typedef logic [LenW-1:0]           len_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MODE       = 1'b0,
    REG_ROW_LENGTH = 1'b1
  } cfg_reg_e;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  localparam len_t LEN_MAX = len_t'(MaxRowLen);
  localparam len_t LEN_ONE = len_t'(1);

endpackage
`default_nettype wire

>>> design/rdc_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rdc_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// Read data holds while the read enable is low.
// ----------------------------------------------------------------------------
module rdc_ram #(
  parameter int Width = 16,
  parameter int Depth = 4096,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

>>> design/row_delta_codec_16bit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// row_delta_codec_16bit
// Vertical delta codec for 16-bit samples: subtracts (encode) or adds back
// (decode) the sample directly above, using a one-row line buffer.
// ----------------------------------------------------------------------------
// Accepts one sample per clock and delivers one result per clock while
// out_ready_i stays high. A sample is registered in stage 1 when it
// transfers and moves into the output register when stage 1 advances.
// The rate is set by the line buffer, which does one read and one write per
// sample; a sample that reads the column the previous sample is writing
// takes the forwarded value. The line buffer is not cleared: the first row
// of every chunk fills it, and a stream should begin with chunk_start. Write
// mode and row_length only while the block is idle.
module row_delta_codec_16bit
  import rdc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [LenW-1:0]     cfg_wdata_i,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic signed [SampleW-1:0] sample_i,
  input  wire logic                chunk_start_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic signed [SampleW-1:0] coded_sample_o
);

  logic    mode_q;
  len_t    row_length_q;
  col_t    col_q;
  logic    first_q;

  logic    s1_v_q;
  sample_t s1_x_q;
  logic    s1_first_q;
  logic    s1_mode_q;
  col_t    s1_col_q;
  logic    fwd_q;
  sample_t fwd_data_q;

  logic    out_v_q;
  sample_t out_data_q;

  logic    in_xfer;
  logic    s1_adv;
  len_t    len;
  col_t    col_cur;
  logic    first_cur;
  len_t    col_inc;
  sample_t rdata;
  sample_t above;
  sample_t y;
  sample_t wval;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_ENCODE;
      row_length_q <= LEN_ONE;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_MODE:       mode_q       <= cfg_wdata_i[0];
        REG_ROW_LENGTH: row_length_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (row_length_q == '0) begin
      len = LEN_ONE;
    end else if (row_length_q > LEN_MAX) begin
      len = LEN_MAX;
    end else begin
      len = row_length_q;
    end
  end

  assign s1_adv     = s1_v_q && (!out_v_q || out_ready_i);
  assign in_ready_o = !s1_v_q || s1_adv;
  assign in_xfer    = in_valid_i && in_ready_o;

  // column tracking
  assign col_cur   = chunk_start_i ? '0 : col_q;
  assign first_cur = chunk_start_i ? 1'b1 : first_q;
  assign col_inc   = {1'b0, col_cur} + LEN_ONE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      first_q <= 1'b1;
    end else if (in_xfer) begin
      if (col_inc >= len) begin
        col_q   <= '0;
        first_q <= 1'b0;
      end else begin
        col_q   <= col_inc[ColW-1:0];
        first_q <= first_cur;
      end
    end
  end

  // line buffer
  rdc_ram #(
    .Width(SampleW),
    .Depth(MaxRowLen)
  ) u_line (
    .clk_i  (clk_i),
    .we_i   (s1_adv),
    .waddr_i(s1_col_q),
    .wdata_i(wval),
    .re_i   (in_xfer),
    .raddr_i(col_cur),
    .rdata_o(rdata)
  );

  // stage 1: modify and write back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      fwd_q  <= 1'b0;
    end else if (in_xfer) begin
      s1_v_q <= 1'b1;
      fwd_q  <= s1_adv && (s1_col_q == col_cur);
    end else if (s1_adv) begin
      s1_v_q <= 1'b0;
      fwd_q  <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_x_q     <= sample_i;
      s1_first_q <= first_cur;
      s1_mode_q  <= mode_q;
      s1_col_q   <= col_cur;
      fwd_data_q <= wval;
    end
  end

  assign above = fwd_q ? fwd_data_q : rdata;

  always_comb begin
    if (s1_first_q) begin
      y = s1_x_q;
    end else if (s1_mode_q == MODE_DECODE) begin
      y = s1_x_q + above;
    end else begin
      y = s1_x_q - above;
    end
  end

  // encode keeps originals, decode keeps reconstructions
  assign wval = (s1_mode_q == MODE_DECODE) ? y : s1_x_q;

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (s1_adv) begin
      out_v_q <= 1'b1;
    end else if (out_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_data_q <= y;
    end
  end

  assign out_valid_o    = out_v_q;
  assign coded_sample_o = out_data_q;

  // checks
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_v_q && out_v_q && !out_ready_i))
    else $error("input stalled while pipeline has room");

  a_fwd_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> s1_v_q)
    else $error("forward flag without item in stage 1");

  a_chunk_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && chunk_start_i) |=> (s1_first_q && s1_col_q == '0))
    else $error("chunk start did not restart row tracking");

  a_adv_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_v_q)
    else $error("result lost between stage 1 and output");

endmodule
`default_nettype wire

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for row_delta_codec_16bit. A queue-fed driver streams
// samples with random gaps. A clocked line-buffer model predicts each coded
// sample, and a monitor compares every output transfer with the oldest
// prediction. Mode and row length are reprogrammed between drained phases.
// ----------------------------------------------------------------------------
module tb;
  import rdc_pkg::*;

  typedef struct packed {
    sample_t sample;
    logic    chunk_start;
  } item_t;

  logic     clk_i         = 1'b0;
  logic     rst_ni        = 1'b0;
  logic     cfg_we_i      = 1'b0;
  cfg_reg_e cfg_index_i   = REG_MODE;
  len_t     cfg_wdata_i   = '0;
  logic     in_valid_i    = 1'b0;
  logic     in_ready_o;
  sample_t  sample_i      = '0;
  logic     chunk_start_i = 1'b0;
  logic     out_valid_o;
  logic     out_ready_i   = 1'b0;
  sample_t  coded_sample_o;

  item_t       item_q[$];
  sample_t     coded_q[$];
  int unsigned idle_pct  = 6;
  int unsigned errors    = 0;
  logic        in_acc    = 1'b0;
  logic        chunk_due = 1'b1;
  int unsigned gen_len   = 1;

  // model state
  sample_t     row_above [MaxRowLen];
  logic        m_mode  = MODE_ENCODE;
  len_t        m_len   = LEN_ONE;
  int unsigned m_col   = 0;
  logic        m_first = 1'b1;

  row_delta_codec_16bit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .sample_i      (sample_i),
    .chunk_start_i (chunk_start_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .coded_sample_o(coded_sample_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned eff_len(len_t len);
    if (len == 0) return 1;
    if (len > LEN_MAX) return MaxRowLen;
    return 32'(len);
  endfunction

  function automatic sample_t rand_sample();
    if ($urandom_range(99) < 8) begin
      case ($urandom_range(3))
        0: return sample_t'(16'sh7fff);
        1: return sample_t'(16'sh8000);
        2: return sample_t'(0);
        default: return sample_t'(-1);
      endcase
    end
    return sample_t'($urandom);
  endfunction

  task automatic report_mismatch(string what, sample_t want, sample_t got);
    $display("mismatch: %s want %0d got %0d at %0t", what, want, got, $time);
    errors++;
  endtask

  task automatic write_reg(cfg_reg_e idx, len_t data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // growing the row needs a fresh chunk so no unwritten column is read
  task automatic program_codec(logic m, len_t len);
    write_reg(REG_MODE, len_t'(m));
    write_reg(REG_ROW_LENGTH, len);
    if (eff_len(len) > gen_len) chunk_due = 1'b1;
    gen_len = eff_len(len);
  endtask

  task automatic queue_sample(sample_t s, logic cs);
    item_q.push_back(item_t'{sample: s, chunk_start: cs | chunk_due});
    chunk_due = 1'b0;
  endtask

  task automatic wait_drained();
    do begin
      @(posedge clk_i);
      #1;
    end while (item_q.size() != 0 || in_valid_i || coded_q.size() != 0);
  endtask

  always @(negedge clk_i) begin : sample_driver
    item_t nxt;
    out_ready_i <= ($urandom_range(99) >= idle_pct);
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_acc) begin
      if (item_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        nxt = item_q.pop_front();
        sample_i      <= nxt.sample;
        chunk_start_i <= nxt.chunk_start;
        in_valid_i    <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : codec_model
    sample_t     above;
    sample_t     result;
    int unsigned col;
    int unsigned len;
    in_acc = rst_ni && in_valid_i && in_ready_o;
    if (rst_ni && cfg_we_i) begin
      if (cfg_index_i == REG_MODE) m_mode = cfg_wdata_i[0];
      else m_len = cfg_wdata_i;
    end
    if (in_acc) begin
      len = eff_len(m_len);
      if (chunk_start_i) begin
        m_col   = 0;
        m_first = 1'b1;
      end
      col   = m_col;
      above = row_above[col];
      if (m_first) begin
        result         = sample_i;
        row_above[col] = sample_i;
      end else if (m_mode == MODE_ENCODE) begin
        result         = sample_i - above;
        row_above[col] = sample_i;
      end else begin
        result         = sample_i + above;
        row_above[col] = result;
      end
      coded_q.push_back(result);
      col++;
      if (col >= len) begin
        m_col   = 0;
        m_first = 1'b0;
      end else begin
        m_col = col;
      end
    end
  end

  always @(posedge clk_i) begin : coded_monitor
    sample_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (coded_q.size() == 0) begin
        report_mismatch("unexpected transfer", '0, coded_sample_o);
      end else begin
        want = coded_q.pop_front();
        if (coded_sample_o !== want) report_mismatch("coded_sample", want, coded_sample_o);
      end
    end
  end

  initial begin : stimulus
    int unsigned rand_items;
    int unsigned len;
    int unsigned n;
    int unsigned r;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // wraparound at both extremes, rows of two
    program_codec(MODE_ENCODE, len_t'(2));
    queue_sample(16'sh7fff, 1'b1);
    queue_sample(16'sh8000, 1'b0);
    queue_sample(16'sh8000, 1'b0);
    queue_sample(16'sh7fff, 1'b0);
    queue_sample(16'sh0000, 1'b0);
    queue_sample(-16'sd1, 1'b0);
    queue_sample(16'sd1, 1'b0);
    queue_sample(16'sh8000, 1'b0);
    wait_drained();
    // mode flip mid-chunk, then restarts at row start and mid-row
    program_codec(MODE_DECODE, len_t'(2));
    queue_sample(16'sh7fff, 1'b0);
    queue_sample(16'sh7fff, 1'b0);
    queue_sample(-16'sd1, 1'b0);
    queue_sample(16'sh8000, 1'b0);
    queue_sample(16'sd5, 1'b1);
    queue_sample(-16'sd5, 1'b0);
    queue_sample(16'sd100, 1'b0);
    queue_sample(16'sd7, 1'b1);
    queue_sample(16'sd8, 1'b0);
    queue_sample(16'sd9, 1'b0);
    wait_drained();
    // zero row length acts as one
    program_codec(MODE_ENCODE, len_t'(0));
    queue_sample(16'sd3, 1'b0);
    queue_sample(-16'sd4, 1'b0);
    queue_sample(16'sh7fff, 1'b0);
    wait_drained();

    // long rows without gaps, then a saturated length opens a long first row
    idle_pct = 0;
    program_codec(MODE_ENCODE, len_t'(256));
    for (int i = 0; i < 2 * 256 + 8; i++) queue_sample(rand_sample(), 1'b0);
    wait_drained();
    program_codec(MODE_DECODE, len_t'(8191));
    for (int i = 0; i < 8; i++) queue_sample(rand_sample(), 1'b0);
    wait_drained();
    idle_pct = 6;

    rand_items = 0;
    while (rand_items < 1360) begin
      r = $urandom_range(99);
      if (r < 5) len = 0;
      else if (r < 80) len = $urandom_range(1, 16);
      else if (r < 95) len = $urandom_range(17, 64);
      else len = $urandom_range(65, 400);
      if ($urandom_range(3) == 0) chunk_due = 1'b1;
      program_codec(logic'($urandom_range(1)), len_t'(len));
      n = $urandom_range(2, 4) * eff_len(len_t'(len)) + $urandom_range(0, 20);
      for (int i = 0; i < n; i++) queue_sample(rand_sample(), $urandom_range(39) == 0);
      rand_items += n;
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #10000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
